// File: rtl/core/btbc_pkg.sv
// Shared constants and types for the byte transition bigram confidence block.
package btbc_pkg;

  localparam int NSTREAM         = 8;
  localparam int NLEVEL          = 5;
  localparam int ROW_SPAN        = NLEVEL * NLEVEL;
  localparam int NENTRY          = NSTREAM * ROW_SPAN;
  localparam int ADDR_W          = $clog2(NENTRY);
  localparam int TOK_W           = 3;
  localparam int PAIR_W          = 17;
  localparam int WARMUP_W        = 16;
  localparam int CONF_W          = 16;
  localparam int ENERGY_W        = 5;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd200;
  localparam logic [TOK_W-1:0]    TOK_MID      = 3'd2;

  typedef logic [TOK_W-1:0]  tok_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// File: rtl/core/btbc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module btbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/byte_transition_bigram_confidence.sv
// Top level of the byte transition bigram confidence block.
//
// Usage: bytes enter on the in_ channel (in_valid / in_stall). After reset the
// first byte is only stored and gives no result. Every later byte forms a pair
// with the byte before it and gives exactly one request on the out_ channel:
// the mean prediction confidence (unsigned Q0.16, zero during warmup), a flag
// that tells whether the warmup count had been reached, and the token energy.
// The warmup length is written through cfg_wr_en / cfg_wr_data, by the user only
// while idle; the block itself does not enforce this.
//
// Timing: one shared restoring divider, one bit per cycle, and one count
// memory port set the rate. During warmup a pair goes from the accept straight
// to the count updates. Once warm, each of the eight streams first takes a row
// scan and FRAC_BITS+1 divider steps, and the count updates follow the last
// stream. in_stall is high from the cycle after an accept that forms a pair
// until the result has been moved into the output register.
//
// Reset clears the sequencer, the pair counter, the previous tokens (to level
// two) and the per-entry valid bits, so every count reads as one at once; no
// clearing pass is needed. The output register holds a finished request while
// out_stall is high, and the next byte is still accepted meanwhile.
module byte_transition_bigram_confidence #(
  parameter int COUNT_WIDTH = btbc_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = btbc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btbc_pkg::CONF_W-1:0]    out_confidence,
  output logic                           out_warmed_up,
  output logic [btbc_pkg::ENERGY_W-1:0]  out_transition_energy,
  input  logic                           cfg_wr_en,
  input  logic [btbc_pkg::WARMUP_W-1:0]  cfg_wr_data
);

  localparam int AW    = btbc_pkg::ADDR_W;
  localparam int TW    = btbc_pkg::TOK_W;
  localparam int NS    = btbc_pkg::NSTREAM;
  localparam int CONFW = btbc_pkg::CONF_W;
  localparam int EW    = btbc_pkg::ENERGY_W;
  localparam int PW    = btbc_pkg::PAIR_W;
  localparam int TOTW  = COUNT_WIDTH + 3;          // sum of five counts
  localparam int REMW  = COUNT_WIDTH + 4;          // remainder before compare
  localparam int QW    = FRAC_BITS + 1;            // quotient never exceeds 2^FRAC_BITS
  localparam int SUMW  = FRAC_BITS + 4;            // sum of eight quotients
  localparam int BW    = $clog2(FRAC_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [2:0]      LAST_STREAM = 3'(NS - 1);
  localparam logic [2:0]      SCAN_LAST   = 3'(btbc_pkg::NLEVEL);
  localparam logic [3:0]      UPD_LAST    = 4'(NS);
  localparam logic [BW-1:0]   DIV_LAST    = BW'(FRAC_BITS);
  localparam logic [PW-1:0]   PAIR_MAX    = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Address of one count: stream, previous token, next token.
  function automatic btbc_pkg::addr_t cell_addr(input logic [2:0] c,
                                                input btbc_pkg::tok_t p,
                                                input btbc_pkg::tok_t n);
    cell_addr = AW'(c) * AW'(btbc_pkg::ROW_SPAN) + AW'(p) * AW'(btbc_pkg::NLEVEL) + AW'(n);
  endfunction

  logic [2:0]                state_r, state_nxt;
  logic [7:0]                prev_byte_r;
  logic                      have_prev_r;
  logic [btbc_pkg::WARMUP_W-1:0] warmup_r;
  logic [PW-1:0]             observed_r;
  btbc_pkg::tok_t            last_r [NS];
  btbc_pkg::tok_t            tok_r  [NS];
  btbc_pkg::tok_t            tok_in [NS];
  logic                      warm_r;
  logic [2:0]                c_r;
  logic [2:0]                j_r;
  logic [BW-1:0]             b_r;
  logic [3:0]                u_r;
  logic [TOTW-1:0]           tot_r;
  logic [COUNT_WIDTH-1:0]    max_r;
  logic [REMW-1:0]           rem_r;
  logic [QW-1:0]             q_r;
  logic [SUMW-1:0]           sum_r;
  btbc_pkg::addr_t           waddr_r;
  logic                      rd_vld_r;
  logic [btbc_pkg::NENTRY-1:0] valid_r;
  logic                      out_valid_r;
  logic [CONFW-1:0]          out_conf_r;
  logic                      out_warm_r;
  logic [EW-1:0]             out_energy_r;

  logic                      in_acc;
  logic                      out_load;
  btbc_pkg::addr_t           ram_raddr;
  logic [COUNT_WIDTH-1:0]    ram_rdata;
  logic                      ram_we;
  logic [COUNT_WIDTH-1:0]    cnt;
  logic [COUNT_WIDTH-1:0]    cnt_inc;
  logic [TOTW-1:0]           tot_fin;
  logic [COUNT_WIDTH-1:0]    max_fin;
  logic [REMW-1:0]           cand;
  logic                      ge;
  logic [REMW-1:0]           rem_nxt;
  logic [QW-1:0]             q_nxt;
  logic [FRAC_BITS:0]        mean_w;
  logic [CONFW-1:0]          conf_w;
  logic [EW-1:0]             energy_w;
  logic [2:0]                scan_col;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign out_valid             = out_valid_r;
  assign out_confidence        = out_conf_r;
  assign out_warmed_up         = out_warm_r;
  assign out_transition_energy = out_energy_r;

  // Tokens of the pair formed by the stored byte and the incoming one.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tok_in[i] = ({2'b00, prev_byte_r[7-2*i]} + {2'b00, prev_byte_r[6-2*i]} + btbc_pkg::TOK_MID)
                - ({2'b00, in_data_byte[7-2*i]} + {2'b00, in_data_byte[6-2*i]});
      tok_in[4+i] = ({2'b00, prev_byte_r[7-2*i]} + {2'b00, in_data_byte[6-2*i]}
                     + btbc_pkg::TOK_MID)
                  - ({2'b00, prev_byte_r[6-2*i]} + {2'b00, in_data_byte[7-2*i]});
    end
  end

  // Energy of the new tokens; they sit in last_r once the updates are done.
  always_comb begin
    energy_w = '0;
    for (int i = 0; i < NS; i++) begin
      if (last_r[i] >= btbc_pkg::TOK_MID) begin
        energy_w = energy_w + EW'(last_r[i] - btbc_pkg::TOK_MID);
      end else begin
        energy_w = energy_w + EW'(btbc_pkg::TOK_MID - last_r[i]);
      end
    end
  end

  // The stream being worked on is always at the head of the token rows,
  // which rotate by one place per stream.
  assign scan_col = (j_r < SCAN_LAST) ? j_r : 3'd0;

  always_comb begin
    if (state_r == ST_UPD) begin
      ram_raddr = cell_addr(u_r[2:0], last_r[0], tok_r[0]);
    end else begin
      ram_raddr = cell_addr(c_r, last_r[0], scan_col);
    end
  end

  // An entry never written reads as one.
  assign cnt     = rd_vld_r ? ram_rdata : COUNT_WIDTH'(1);
  assign cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
  assign ram_we  = (state_r == ST_UPD) && (u_r != 4'd0);

  btbc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (btbc_pkg::NENTRY)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_r),
    .wdata (cnt_inc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Row total and maximum including the count that arrives this cycle.
  always_comb begin
    if (j_r == 3'd1) begin
      tot_fin = TOTW'(cnt);
      max_fin = cnt;
    end else begin
      tot_fin = tot_r + TOTW'(cnt);
      max_fin = (cnt > max_r) ? cnt : max_r;
    end
  end

  // One restoring division step.
  always_comb begin
    cand    = (b_r == '0) ? rem_r : {rem_r[REMW-2:0], 1'b0};
    ge      = (cand >= REMW'(tot_r));
    rem_nxt = ge ? cand - REMW'(tot_r) : cand;
    q_nxt   = {q_r[QW-2:0], ge};
  end

  assign mean_w = sum_r[SUMW-1:3];

  generate
    if (FRAC_BITS >= CONFW) begin : g_align_down
      assign conf_w = mean_w[FRAC_BITS-CONFW +: CONFW];
    end else begin : g_align_up
      assign conf_w = CONFW'({mean_w, {(CONFW-FRAC_BITS){1'b0}}});
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && have_prev_r) begin
          state_nxt = (observed_r >= PW'(warmup_r)) ? ST_SCAN : ST_UPD;
        end
      end
      ST_SCAN: begin
        if (j_r == SCAN_LAST) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (b_r == DIV_LAST) begin
          state_nxt = (c_r == LAST_STREAM) ? ST_UPD : ST_SCAN;
        end
      end
      ST_UPD: begin
        if (u_r == UPD_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_byte_r <= '0;
      warmup_r    <= btbc_pkg::WARMUP_RESET;
      observed_r  <= '0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      c_r         <= '0;
      j_r         <= '0;
      b_r         <= '0;
      u_r         <= '0;
      for (int i = 0; i < NS; i++) begin
        last_r[i] <= btbc_pkg::TOK_MID;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= valid_r[ram_raddr];
      if (cfg_wr_en) begin
        warmup_r <= cfg_wr_data;
      end
      if (ram_we) begin
        valid_r[waddr_r] <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            prev_byte_r <= in_data_byte;
            have_prev_r <= 1'b1;
            c_r <= '0;
            j_r <= '0;
            b_r <= '0;
            u_r <= '0;
          end
        end
        ST_SCAN: begin
          j_r <= j_r + 3'd1;
          if (j_r == SCAN_LAST) begin
            j_r <= '0;
          end
        end
        ST_DIV: begin
          b_r <= b_r + BW'(1);
          if (b_r == DIV_LAST) begin
            b_r <= '0;
            c_r <= c_r + 3'd1;
            for (int i = 0; i < NS; i++) begin
              last_r[i] <= last_r[(i+1) % NS];
            end
          end
        end
        ST_UPD: begin
          u_r <= u_r + 4'd1;
          if (u_r == UPD_LAST) begin
            for (int i = 0; i < NS; i++) begin
              last_r[i] <= tok_r[i];
            end
            if (observed_r != PAIR_MAX) begin
              observed_r <= observed_r + PW'(1);
            end
          end else begin
            for (int i = 0; i < NS; i++) begin
              last_r[i] <= last_r[(i+1) % NS];
            end
          end
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; control above decides when they matter.
  always_ff @(posedge clk) begin
    waddr_r <= ram_raddr;
    if (in_acc) begin
      warm_r <= (observed_r >= PW'(warmup_r));
      sum_r  <= '0;
      for (int i = 0; i < NS; i++) begin
        tok_r[i] <= tok_in[i];
      end
    end
    if (state_r == ST_SCAN && j_r != 3'd0) begin
      tot_r <= tot_fin;
      max_r <= max_fin;
      if (j_r == SCAN_LAST) begin
        rem_r <= REMW'(max_fin);
      end
    end
    if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (b_r == DIV_LAST) begin
        sum_r <= sum_r + SUMW'(q_nxt);
      end
    end
    if (state_r == ST_UPD && u_r != UPD_LAST) begin
      for (int i = 0; i < NS; i++) begin
        tok_r[i] <= tok_r[(i+1) % NS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_conf_r   <= warm_r ? conf_w : '0;
      out_warm_r   <= warm_r;
      out_energy_r <= energy_w;
    end
  end

`ifndef SYNTHESIS
  // Confidence is only reported once warm.
  a_cold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_warm_r |-> out_conf_r == '0)
    else $error("confidence nonzero during warmup");

  // Energy of eight tokens cannot pass sixteen.
  a_energy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_energy_r <= EW'(16))
    else $error("transition energy out of range");

  // The divider never sees an empty row.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> tot_r != '0)
    else $error("division by zero row total");

  // An update write never hits the entry being read in the same cycle.
  a_upd_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && u_r != UPD_LAST |-> waddr_r != ram_raddr)
    else $error("count update read and write collide");
`endif

endmodule
